@@ rtl/core/dtms_pkg.sv @@
// ============================================================================
// dtms_pkg
// Types, constants and the unit table shared by the duration text parser.
// ============================================================================
`default_nettype none

package dtms_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Unit scale factors in milliseconds.
    localparam int unsigned SCALE_W = 22;
    localparam logic [SCALE_W-1:0] SCALE_MS   = 22'd1;
    localparam logic [SCALE_W-1:0] SCALE_SEC  = 22'd1000;
    localparam logic [SCALE_W-1:0] SCALE_MIN  = 22'd60000;
    localparam logic [SCALE_W-1:0] SCALE_HOUR = 22'd3600000;

    // Token length saturates here; a token this long never matches.
    localparam logic [2:0] TOKEN_LEN_SAT = 3'd5;

    // Packed token spellings, newest character in the low byte.
    localparam logic [31:0] TOK_S    = 32'h0000_0073;
    localparam logic [31:0] TOK_H    = 32'h0000_0068;
    localparam logic [31:0] TOK_MS   = 32'h0000_6D73;
    localparam logic [31:0] TOK_MN   = 32'h0000_6D6E;
    localparam logic [31:0] TOK_HR   = 32'h0000_6872;
    localparam logic [31:0] TOK_SEC  = 32'h0073_6563;
    localparam logic [31:0] TOK_MIN  = 32'h006D_696E;
    localparam logic [31:0] TOK_MSEC = 32'h6D73_6563;

    // One input beat.
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } dtms_in_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] total_ms;
        logic        parse_ok;
    } dtms_out_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic        reading_number;
        logic        digit_seen;
        logic [31:0] number_value;
        logic [31:0] token_chars;
        logic [2:0]  token_length;
        logic [31:0] running_total;
        logic        unit_found;
        logic        error_seen;
    } dtms_state_t;

    localparam dtms_state_t STATE_RESET = '{
        reading_number: 1'b1,
        digit_seen:     1'b0,
        number_value:   32'd0,
        token_chars:    32'd0,
        token_length:   3'd0,
        running_total:  32'd0,
        unit_found:     1'b0,
        error_seen:     1'b0
    };

    // Scale of a unit token; zero means the token is not a unit.
    function automatic logic [SCALE_W-1:0] unit_scale(input logic [31:0] chars,
                                                      input logic [2:0]  len);
        logic [SCALE_W-1:0] scale;
        scale = '0;
        case (len)
            3'd1: begin
                if (chars == TOK_S)      scale = SCALE_SEC;
                else if (chars == TOK_H) scale = SCALE_HOUR;
            end
            3'd2: begin
                if (chars == TOK_MS)      scale = SCALE_MS;
                else if (chars == TOK_MN) scale = SCALE_MIN;
                else if (chars == TOK_HR) scale = SCALE_HOUR;
            end
            3'd3: begin
                if (chars == TOK_SEC)      scale = SCALE_SEC;
                else if (chars == TOK_MIN) scale = SCALE_MIN;
            end
            3'd4: begin
                if (chars == TOK_MSEC) scale = SCALE_MS;
            end
            default: begin
                scale = '0;
            end
        endcase
        return scale;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dtms_unit_match.sv @@
// ============================================================================
// dtms_unit_match
// Matches the collected token against the unit table and scales the number.
// ============================================================================
`default_nettype none

module dtms_unit_match
    import dtms_pkg::*;
(
    input  wire logic [31:0] token_chars,
    input  wire logic [2:0]  token_length,
    input  wire logic [31:0] number_value,
    output logic             unit_hit,
    output logic [31:0]      scaled_value
);

    logic [SCALE_W-1:0]      scale;
    logic [31+SCALE_W:0]     product;

    // Look up the scale and multiply by the constant it selects.
    always_comb begin
        scale        = unit_scale(token_chars, token_length);
        unit_hit     = (scale != '0);
        product      = number_value * scale;
        scaled_value = product[31:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/dtms_char_step.sv @@
// ============================================================================
// dtms_char_step
// Next-state and result logic for one character of the duration text.
// ============================================================================
`default_nettype none

module dtms_char_step
    import dtms_pkg::*;
(
    input  wire dtms_state_t cur_state,
    input  wire dtms_in_t    in_beat,
    output dtms_state_t      next_state,
    output dtms_out_t        result
);

    logic        is_space;
    logic        is_digit;
    logic [31:0] digit_value;
    logic        close_req;
    logic        digit_after_close;
    logic        unit_hit;
    logic [31:0] scaled_value;
    dtms_state_t mid_state;

    // Character classes; a decimal digit's value is its low nibble.
    assign is_space    = (in_beat.text_char == CHAR_SPACE);
    assign is_digit    = (in_beat.text_char >= CHAR_ZERO) && (in_beat.text_char <= CHAR_NINE);
    assign digit_value = {28'd0, in_beat.text_char[3:0]};

    // Token updates and the close request; the number is not touched when a
    // token closes, so the multiplier always sees the current number.
    always_comb begin
        mid_state         = cur_state;
        close_req         = 1'b0;
        digit_after_close = 1'b0;
        if (!cur_state.error_seen) begin
            if (cur_state.reading_number) begin
                if (is_space) begin
                    mid_state = cur_state;
                end else if (is_digit) begin
                    mid_state.number_value = (cur_state.number_value << 3)
                                           + (cur_state.number_value << 1) + digit_value;
                    mid_state.digit_seen   = 1'b1;
                end else if (!cur_state.digit_seen) begin
                    mid_state.error_seen = 1'b1;
                end else begin
                    mid_state.reading_number = 1'b0;
                    mid_state.token_chars    = {24'd0, in_beat.text_char};
                    mid_state.token_length   = 3'd1;
                end
            end else if (is_space || is_digit) begin
                close_req         = 1'b1;
                digit_after_close = is_digit;
            end else begin
                mid_state.token_chars = {cur_state.token_chars[23:0], in_beat.text_char};
                if (cur_state.token_length < TOKEN_LEN_SAT) begin
                    mid_state.token_length = cur_state.token_length + 3'd1;
                end
            end
        end
        // A token still open at the end of the text is closed as well.
        if (in_beat.is_last && !mid_state.error_seen && !mid_state.reading_number) begin
            close_req = 1'b1;
        end
    end

    dtms_unit_match u_unit_match (
        .token_chars  (mid_state.token_chars),
        .token_length (mid_state.token_length),
        .number_value (cur_state.number_value),
        .unit_hit     (unit_hit),
        .scaled_value (scaled_value)
    );

    // Apply the unit, check for a dangling number, form the result and clear
    // the state after the last character.
    always_comb begin
        next_state = mid_state;
        if (close_req) begin
            if (!unit_hit) begin
                next_state.error_seen = 1'b1;
            end else begin
                next_state.running_total  = mid_state.running_total + scaled_value;
                next_state.number_value   = 32'd0;
                next_state.reading_number = 1'b1;
                next_state.digit_seen     = 1'b0;
                next_state.unit_found     = 1'b1;
                next_state.token_chars    = 32'd0;
                next_state.token_length   = 3'd0;
                if (digit_after_close) begin
                    next_state.number_value = digit_value;
                    next_state.digit_seen   = 1'b1;
                end
            end
        end
        if (in_beat.is_last && !next_state.error_seen && next_state.reading_number
            && next_state.digit_seen) begin
            next_state.error_seen = 1'b1;
        end
        result.parse_ok = !next_state.error_seen && next_state.unit_found;
        result.total_ms = result.parse_ok ? next_state.running_total : 32'd0;
        if (in_beat.is_last) begin
            next_state = STATE_RESET;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/duration_text_to_milliseconds.sv @@
// ============================================================================
// duration_text_to_milliseconds
// Parses a duration text such as "1 h 23 mn 5 s" into milliseconds.
// ============================================================================
// Characters arrive on the s_ channel, one per beat, with is_last marking the
// final character of a string. Only the last character yields a beat on the
// m_ channel: total_ms (modulo 2^32) and parse_ok; earlier characters yield
// nothing. After the last character the parser clears itself for the next
// string.
// A last character is taken into the input register and passes through the parser
// into the result register, which drives m_valid; it waits in the input register
// while the result register still holds a result that has not been taken.
// Throughput: one character per cycle unless a last character waits; the parser
// state, the token match and the constant multiply-accumulate update together
// from the input register, so characters may follow each other back to back.
// When the receiver stalls, the result stays in the output register and
// characters keep flowing until a further last character has to wait for it;
// s_ready then drops until m_ready frees the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to its idle state; no result is pending afterwards.
// ============================================================================
`default_nettype none

module duration_text_to_milliseconds
    import dtms_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dtms_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dtms_out_t     m_data
);

    dtms_in_t    in_reg;
    logic        in_valid_reg;
    dtms_state_t state_reg;
    dtms_state_t state_next;
    dtms_out_t   out_reg;
    dtms_out_t   out_next;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    // A character leaves the input register unless it is a last character
    // whose result cannot yet be stored.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_reg.is_last || out_free);
    assign s_ready  = !in_valid_reg || advance;

    dtms_char_step u_char_step (
        .cur_state  (state_reg),
        .in_beat    (in_reg),
        .next_state (state_next),
        .result     (out_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_reg.is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_reg.is_last) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ============================================================================
// tb
// Self-checking bench for the duration text to milliseconds parser.
// ============================================================================
// A short table of hand-picked strings comes first. It covers several unit
// tokens, character extremes, a unit with no number, an unknown token, a
// token that is too long and a number left without a unit. Random strings
// follow. Most of them are well-formed sequences of numbers and units, with
// occasional damage, and the rest are byte noise. Every accepted character is
// run through a behavioural parser kept in the bench. Each result beat is
// compared with the oldest predicted duration. Both the sender and the
// receiver pause at random, with calm stretches in between.
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dtms_pkg::*;

    localparam int unsigned TEXT_CHARS  = 1400;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_AFTER = 70;

    localparam logic [31:0] MS_PER_SEC  = 32'd1000;
    localparam logic [31:0] MS_PER_MIN  = 32'd60000;
    localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
    localparam logic [31:0] MS_PER_MS   = 32'd1;

    // One row of the directed table; typed rows carry their own duration.
    typedef struct packed {
        logic [7:0]  ch;
        logic        is_end;
        logic        typed;
        logic [31:0] total;
        logic        ok;
    } dir_row_t;

    localparam int N_DIRECTED = 26;
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // "5s": plain seconds.
        '{"5", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"s", 1'b1, 1'b1, 32'd5000, 1'b1},
        // "1h2": a digit ends the token, then the number is left over.
        '{"1", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"h", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"2", 1'b1, 1'b1, 32'd0, 1'b0},
        // NUL first: a unit without a number, the rest is ignored.
        '{8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
        '{"1", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"m", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"s", 1'b1, 1'b1, 32'd0, 1'b0},
        // A top-bit byte as a token is unknown.
        '{"7", 1'b0, 1'b0, 32'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 32'd0, 1'b0},
        // A lone space: no unit at all.
        '{" ", 1'b1, 1'b1, 32'd0, 1'b0},
        // "3msec": the four-character unit.
        '{"3", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"m", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"s", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"e", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"c", 1'b1, 1'b0, 32'd0, 1'b0},
        // "2xmsec": a five-character token never matches, even though its
        // last four characters spell a unit.
        '{"2", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"x", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"m", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"s", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"e", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"c", 1'b1, 1'b1, 32'd0, 1'b0},
        // "9hr": hours, closed by the last mark.
        '{"9", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"h", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"r", 1'b1, 1'b0, 32'd0, 1'b0}
    };

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    dtms_in_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dtms_out_t m_data;

    string      unit_names [8] = '{"ms", "msec", "s", "sec", "mn", "min", "h", "hr"};
    string      noise_alphabet = "0123456789 msecinhr";

    dtms_state_t parse_st = STATE_RESET;
    dtms_out_t   pending_durations [$];
    logic [7:0]  text_bytes [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    duration_text_to_milliseconds u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Milliseconds per unit for a completed token; zero when it is no unit.
    function automatic logic [31:0] unit_weight(input logic [31:0] chars,
                                                input logic [2:0]  len);
        logic [31:0] w;
        w = 32'd0;
        case (chars)
            TOK_S:    if (len == 3'd1) w = MS_PER_SEC;
            TOK_H:    if (len == 3'd1) w = MS_PER_HOUR;
            TOK_MS:   if (len == 3'd2) w = MS_PER_MS;
            TOK_MN:   if (len == 3'd2) w = MS_PER_MIN;
            TOK_HR:   if (len == 3'd2) w = MS_PER_HOUR;
            TOK_SEC:  if (len == 3'd3) w = MS_PER_SEC;
            TOK_MIN:  if (len == 3'd3) w = MS_PER_MIN;
            TOK_MSEC: if (len == 3'd4) w = MS_PER_MS;
            default:  w = 32'd0;
        endcase
        return w;
    endfunction

    // Applies the pending token to the running total, or flags it as bad.
    function automatic void apply_unit();
        logic [31:0] w;
        w = unit_weight(parse_st.token_chars, parse_st.token_length);
        if (w == 32'd0) begin
            parse_st.error_seen = 1'b1;
        end else begin
            parse_st.running_total  = parse_st.running_total + parse_st.number_value * w;
            parse_st.number_value   = 32'd0;
            parse_st.reading_number = 1'b1;
            parse_st.digit_seen     = 1'b0;
            parse_st.unit_found     = 1'b1;
            parse_st.token_chars    = 32'd0;
            parse_st.token_length   = 3'd0;
        end
    endfunction

    // Advances the parser by one character and yields the duration on the
    // last one.
    function automatic void predict_duration(input dtms_in_t beat, output bit has_res,
                                             output dtms_out_t res);
        logic [7:0] c;
        logic       is_digit;
        c        = beat.text_char;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        has_res  = 1'b0;
        res      = '0;

        if (!parse_st.error_seen) begin
            if (parse_st.reading_number) begin
                if (c == CHAR_SPACE) begin
                    // Spaces between items are skipped.
                end else if (is_digit) begin
                    parse_st.number_value = parse_st.number_value * 32'd10
                                            + 32'(c - CHAR_ZERO);
                    parse_st.digit_seen   = 1'b1;
                end else if (!parse_st.digit_seen) begin
                    parse_st.error_seen = 1'b1;
                end else begin
                    parse_st.reading_number = 1'b0;
                    parse_st.token_chars    = {24'd0, c};
                    parse_st.token_length   = 3'd1;
                end
            end else if (c == CHAR_SPACE || is_digit) begin
                // A space or a digit closes the token; a digit starts the next number.
                apply_unit();
                if (!parse_st.error_seen && is_digit) begin
                    parse_st.number_value = 32'(c - CHAR_ZERO);
                    parse_st.digit_seen   = 1'b1;
                end
            end else begin
                parse_st.token_chars = {parse_st.token_chars[23:0], c};
                if (parse_st.token_length < TOKEN_LEN_SAT)
                    parse_st.token_length = parse_st.token_length + 3'd1;
            end
        end

        if (beat.is_last) begin
            if (!parse_st.error_seen && !parse_st.reading_number) apply_unit();
            if (!parse_st.error_seen && parse_st.reading_number && parse_st.digit_seen)
                parse_st.error_seen = 1'b1;
            has_res = 1'b1;
            res.parse_ok = !parse_st.error_seen && parse_st.unit_found;
            res.total_ms = res.parse_ok ? parse_st.running_total : 32'd0;
            parse_st = STATE_RESET;
        end
    endfunction

    // Drives one character beat, after an optional gap, and records its duration.
    task automatic send_char(input dtms_in_t beat, input bit typed,
                             input dtms_out_t typed_res, input bit gaps);
        int unsigned gap;
        bit          has_res;
        dtms_out_t   res;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_duration(beat, has_res, res);
        if (has_res) pending_durations.push_back(typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted duration has come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_durations.size() != 0);
    endtask

    // Builds one random string: mostly number-unit groups, sometimes noise.
    task automatic compose_text();
        int unsigned groups;
        int unsigned ndig;
        int unsigned pos;
        string       unit;
        text_bytes.delete();
        if ($urandom_range(0, 99) < 80) begin
            groups = $urandom_range(1, 4);
            for (int g = 0; g < groups; g++) begin
                repeat ($urandom_range(0, 1)) text_bytes.push_back(CHAR_SPACE);
                ndig = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 10)
                                                    : $urandom_range(1, 3);
                repeat (ndig) text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 1)) text_bytes.push_back(CHAR_SPACE);
                unit = unit_names[$urandom_range(0, 7)];
                for (int i = 0; i < unit.len(); i++) text_bytes.push_back(unit[i]);
            end
            repeat ($urandom_range(0, 1)) text_bytes.push_back(CHAR_SPACE);
            // Occasional damage: a stray byte, a dangling digit or a flipped case bit.
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, text_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0: begin
                        text_bytes[pos] = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    end
                    default: begin
                        text_bytes[pos] = text_bytes[pos] ^ 8'h20;
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1) == 0)
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    text_bytes.push_back(noise_alphabet[$urandom_range(0,
                                         noise_alphabet.len() - 1)]);
            end
        end
    endtask

    // Compares every result beat with the oldest predicted duration.
    always @(posedge aclk) begin
        dtms_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_durations.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("Unexpected result beat: total_ms=%0d parse_ok=%0b",
                             m_data.total_ms, m_data.parse_ok);
                mismatch_count++;
            end else begin
                want = pending_durations.pop_front();
                if (m_data.total_ms !== want.total_ms || m_data.parse_ok !== want.parse_ok) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("Mismatch: expected total_ms=%0d parse_ok=%0b, got total_ms=%0d parse_ok=%0b",
                                 want.total_ms, want.parse_ok, m_data.total_ms, m_data.parse_ok);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: drops m_ready for a random stall before taking a result, except in calm stretches.
    initial begin
        int unsigned stall;
        int unsigned burst_left;
        bit          calm;
        burst_left = 0;
        calm       = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (burst_left == 0) begin
                calm       = ($urandom_range(0, 2) == 0);
                burst_left = $urandom_range(5, 20);
            end
            burst_left--;
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Sender: reset, the directed table, then random strings.
    initial begin
        dtms_in_t    beat;
        dtms_out_t   typed_res;
        int unsigned chars_sent;
        int unsigned strings_sent;
        bit          gaps;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            beat.text_char     = DIRECTED_ROWS[i].ch;
            beat.is_last       = DIRECTED_ROWS[i].is_end;
            typed_res.total_ms = DIRECTED_ROWS[i].total;
            typed_res.parse_ok = DIRECTED_ROWS[i].ok;
            send_char(beat, DIRECTED_ROWS[i].typed, typed_res, 1'b1);
        end
        wait_for_drain();

        chars_sent   = 0;
        strings_sent = 0;
        while (chars_sent < TEXT_CHARS) begin
            compose_text();
            gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < text_bytes.size(); i++) begin
                beat.text_char = text_bytes[i];
                beat.is_last   = (i == text_bytes.size() - 1);
                send_char(beat, 1'b0, '0, gaps);
            end
            chars_sent += text_bytes.size();
            strings_sent++;
            if (strings_sent == DRAIN_AFTER) wait_for_drain();
        end
        s_valid <= 1'b0;

        while (pending_durations.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_durations.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
